@@ rtl/console_escape_translator_fifo_assert.svh @@
// Assertion macros shared by the console receive block.
`ifndef CONSOLE_ESCAPE_TRANSLATOR_FIFO_ASSERT_SVH
`define CONSOLE_ESCAPE_TRANSLATOR_FIFO_ASSERT_SVH

// Same-cycle implication, masked while in reset.
`define CET_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("console rx: same-cycle check failed");

// Next-cycle implication, masked while in reset.
`define CET_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("console rx: next-cycle check failed");

`endif

@@ rtl/cet_pkg.sv @@
package cet_pkg;

  // Parser mode, one-hot
  typedef enum logic [3:0] {
    ModeIdle      = 4'b0001,
    ModeEsc       = 4'b0010,
    ModeEscBrkt   = 4'b0100,
    ModeCtrl      = 4'b1000
  } mode_e;

  // Console command codes
  typedef enum logic [3:0] {
    CmdNone       = 4'd0,
    CmdQuit       = 4'd1,
    CmdDevices    = 4'd2,
    CmdRegs       = 4'd3,
    CmdMemlog     = 4'd4,
    CmdSuspend    = 4'd5,
    CmdResume     = 4'd6,
    CmdTlb        = 4'd7,
    CmdBlocks     = 4'd8,
    CmdConfig     = 4'd9,
    CmdStats      = 4'd10,
    CmdExperiment = 4'd11,
    CmdHelp       = 4'd12
  } cmd_e;

  // Input kinds
  localparam logic KindRx   = 1'b0;
  localparam logic KindRead = 1'b1;

  // Special bytes
  localparam logic [7:0] ChEsc     = 8'h1b;
  localparam logic [7:0] ChBracket = 8'h5b;
  localparam logic [7:0] ChCtrlBr  = 8'h1d;
  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChUp      = 8'h41;
  localparam logic [7:0] ChDown    = 8'h42;
  localparam logic [7:0] ChRight   = 8'h43;
  localparam logic [7:0] ChLeft    = 8'h44;

  // Translated arrow key codes
  localparam logic [7:0] KeyUp    = 8'd16;
  localparam logic [7:0] KeyDown  = 8'd14;
  localparam logic [7:0] KeyRight = 8'd6;
  localparam logic [7:0] KeyLeft  = 8'd2;

  // Classified operation passed from the parser to the FIFO side
  typedef struct packed {
    logic       is_read;
    logic       st0_v;
    logic [7:0] st0;
    logic       st1_v;   // second store, only with st0_v
    logic [7:0] st1;
    cmd_e       cmd;
  } op_t;

  // Op queue status
  typedef struct packed {
    logic ready;  // room for one more op
    logic valid;  // head op present
  } q_stat_t;

  // Command letter lookup after Ctrl-]
  function automatic cmd_e command_code(input logic [7:0] b);
    cmd_e c;
    case (b)
      "q":     c = CmdQuit;
      "d":     c = CmdDevices;
      "r":     c = CmdRegs;
      "m":     c = CmdMemlog;
      "s":     c = CmdSuspend;
      "u":     c = CmdResume;
      "t":     c = CmdTlb;
      "b":     c = CmdBlocks;
      "c":     c = CmdConfig;
      "j":     c = CmdStats;
      "x":     c = CmdExperiment;
      default: c = CmdHelp;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/cet_front.sv @@
module cet_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_kind_i,
  input  logic [7:0]     in_byte_i,
  output logic           in_ready_o,
  output logic           op_valid_o,
  output cet_pkg::op_t   op_o,
  input  logic           op_ready_i
);

  cet_pkg::mode_e mode_q, mode_d;
  cet_pkg::op_t   op;
  logic           accept;

  assign in_ready_o = op_ready_i;
  assign op_valid_o = in_valid_i;
  assign accept     = in_valid_i & op_ready_i;
  assign op_o       = op;

  // Classify one item and step the escape parser
  always_comb begin
    op      = '0;
    op.cmd  = cet_pkg::CmdNone;
    mode_d  = mode_q;
    if (in_kind_i == cet_pkg::KindRead) begin
      op.is_read = 1'b1;
    end else begin
      unique case (mode_q)
        cet_pkg::ModeIdle: begin
          if (in_byte_i == cet_pkg::ChEsc) begin
            mode_d = cet_pkg::ModeEsc;
          end else if (in_byte_i == cet_pkg::ChCtrlBr) begin
            mode_d = cet_pkg::ModeCtrl;
          end else if (in_byte_i != cet_pkg::ChNul) begin
            op.st0_v = 1'b1;
            op.st0   = in_byte_i;
          end
        end
        cet_pkg::ModeEsc: begin
          if (in_byte_i == cet_pkg::ChBracket) begin
            mode_d = cet_pkg::ModeEscBrkt;
          end else begin
            // lone ESC: keep both bytes
            op.st0_v = 1'b1;
            op.st0   = cet_pkg::ChEsc;
            op.st1_v = 1'b1;
            op.st1   = in_byte_i;
            mode_d   = cet_pkg::ModeIdle;
          end
        end
        cet_pkg::ModeEscBrkt: begin
          case (in_byte_i)
            cet_pkg::ChUp: begin
              op.st0_v = 1'b1;
              op.st0   = cet_pkg::KeyUp;
            end
            cet_pkg::ChDown: begin
              op.st0_v = 1'b1;
              op.st0   = cet_pkg::KeyDown;
            end
            cet_pkg::ChRight: begin
              op.st0_v = 1'b1;
              op.st0   = cet_pkg::KeyRight;
            end
            cet_pkg::ChLeft: begin
              op.st0_v = 1'b1;
              op.st0   = cet_pkg::KeyLeft;
            end
            default: ;
          endcase
          mode_d = cet_pkg::ModeIdle;
        end
        cet_pkg::ModeCtrl: begin
          if (in_byte_i == cet_pkg::ChCtrlBr) begin
            op.st0_v = 1'b1;
            op.st0   = cet_pkg::ChCtrlBr;
          end else begin
            op.cmd = cet_pkg::command_code(in_byte_i);
          end
          mode_d = cet_pkg::ModeIdle;
        end
        default: mode_d = cet_pkg::ModeIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cet_pkg::ModeIdle;
    end else if (accept) begin
      mode_q <= mode_d;
    end
  end

endmodule

@@ rtl/cet_queue.sv @@
module cet_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cet_pkg::op_t      push_op_i,
  input  logic              pop_i,
  output cet_pkg::op_t      head_o,
  output cet_pkg::q_stat_t  stat_o
);

  // Two-entry op queue
  cet_pkg::op_t slot_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   cnt_q;
  logic         do_push, do_pop;

  assign stat_o.ready = (cnt_q != 2'd2);
  assign stat_o.valid = (cnt_q != 2'd0);
  assign do_push      = push_i & stat_o.ready;
  assign do_pop       = pop_i & stat_o.valid;
  assign head_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

@@ rtl/cet_back.sv @@
module cet_back #(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cet_pkg::op_t   head_i,
  input  logic           head_valid_i,
  output logic           pop_o,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output logic           read_valid_o,
  output logic [7:0]     read_char_o,
  output logic           char_available_o,
  output logic [3:0]     command_o,
  output logic [1:0]     dropped_o
);

  localparam int unsigned IdxW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FIFO_DEPTH - 1);

  // Ring store, no reset
  logic [7:0]      mem_q [FIFO_DEPTH];
  logic [7:0]      rd_data_q;
  logic [IdxW-1:0] wr_q, wr_d, rd_q, rd_d, wr_nxt, rd_nxt;
  logic            phase_q, phase_d, drop_acc_q, drop_acc_d;
  logic            out_valid_q;
  logic            res_rv_q, res_avail_q;
  cet_pkg::cmd_e   res_cmd_q;
  logic [1:0]      res_drop_q, drop_sum;
  logic            first_step, out_free, finish;
  logic            wen_req, wen, ren, full, drop_now;
  logic [7:0]      wbyte;

  assign wr_nxt = (wr_q == LastIdx) ? '0 : wr_q + 1'b1;
  assign rd_nxt = (rd_q == LastIdx) ? '0 : rd_q + 1'b1;
  assign full   = (wr_nxt == rd_q);

  // Sequencing: a two-byte store writes its first byte in a step of its own
  assign first_step = head_valid_i & head_i.st1_v & ~phase_q;
  assign out_free   = ~out_valid_q | res_ready_i;
  assign finish     = head_valid_i & ~first_step & out_free;
  assign pop_o      = finish;

  // Store and pop for this cycle
  always_comb begin
    wen_req    = first_step | (finish & (phase_q | head_i.st0_v));
    wbyte      = (finish & phase_q) ? head_i.st1 : head_i.st0;
    wen        = wen_req & ~full;
    drop_now   = wen_req & full;
    wr_d       = wen ? wr_nxt : wr_q;
    ren        = finish & head_i.is_read & (rd_q != wr_q);
    rd_d       = ren ? rd_nxt : rd_q;
    phase_d    = phase_q;
    drop_acc_d = drop_acc_q;
    if (first_step) begin
      phase_d    = 1'b1;
      drop_acc_d = drop_now;
    end else if (finish) begin
      phase_d = 1'b0;
    end
    drop_sum = {1'b0, phase_q & drop_acc_q} + {1'b0, drop_now};
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem_q[wr_q] <= wbyte;
    end
    if (ren) begin
      rd_data_q <= mem_q[rd_q];
    end
  end

  // Indices and sequencing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q        <= '0;
      rd_q        <= '0;
      phase_q     <= 1'b0;
      drop_acc_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wr_q       <= wr_d;
      rd_q       <= rd_d;
      phase_q    <= phase_d;
      drop_acc_q <= drop_acc_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (finish) begin
      res_rv_q    <= ren;
      res_avail_q <= (rd_d != wr_d);
      res_cmd_q   <= head_i.cmd;
      res_drop_q  <= drop_sum;
    end
  end

  assign res_valid_o      = out_valid_q;
  assign read_valid_o     = res_rv_q;
  assign read_char_o      = res_rv_q ? rd_data_q : 8'h00;
  assign char_available_o = res_avail_q;
  assign command_o        = res_cmd_q;
  assign dropped_o        = res_drop_q;

endmodule

@@ rtl/console_escape_translator_fifo.sv @@
// Console receive front end with a byte FIFO.
// Slave stream: one request per beat. tuser is the kind (0 = console byte,
// 1 = guest read request); tdata carries the console byte.
// Master stream: exactly one result per request, in request order, 16-bit
// tdata holding read_valid, read_char, char_available, command, dropped.
// A parser turns ESC [ A-D into arrow codes and Ctrl-] letters into
// console commands; other nonzero bytes go into a ring FIFO that holds
// FIFO_DEPTH-1 bytes, extra bytes being dropped and counted.
// A request passes through the op queue and the result register before its
// result is valid on the master side. Throughput: one request per cycle while
// the master side takes results; a lone ESC followed by a non-bracket byte
// needs a separate step per byte, since the ring store has one write port.
// A two-entry op queue separates parser and FIFO side; when the master
// side stalls the queue fills and s_axis_tready falls after at most two
// more beats.
// Reset clears the parser to idle and empties the FIFO; stored bytes are
// not cleared and no clearing pass is needed.
module console_escape_translator_fifo #(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        s_axis_tuser_i,   // [0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [0] read_valid, [8:1] read_char,
                                        // [9] char_available, [13:10] command,
                                        // [15:14] dropped
);

  cet_pkg::op_t     front_op, head_op;
  cet_pkg::q_stat_t q_stat;
  logic             front_valid, pop;
  logic             read_valid, char_available;
  logic [7:0]       read_char;
  logic [3:0]       command;
  logic [1:0]       dropped;
  logic             res_read, res_drop, read_side_clear;

  // Parser
  cet_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_kind_i  (s_axis_tuser_i),
    .in_byte_i  (s_axis_tdata_i),
    .in_ready_o (s_axis_tready_o),
    .op_valid_o (front_valid),
    .op_o       (front_op),
    .op_ready_i (q_stat.ready)
  );

  // Op queue
  cet_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (front_valid),
    .push_op_i (front_op),
    .pop_i     (pop),
    .head_o    (head_op),
    .stat_o    (q_stat)
  );

  // Ring FIFO and result register
  cet_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head_op),
    .head_valid_i     (q_stat.valid),
    .pop_o            (pop),
    .res_valid_o      (m_axis_tvalid_o),
    .res_ready_i      (m_axis_tready_i),
    .read_valid_o     (read_valid),
    .read_char_o      (read_char),
    .char_available_o (char_available),
    .command_o        (command),
    .dropped_o        (dropped)
  );

  assign m_axis_tdata_o = {dropped, command, char_available, read_char, read_valid};

  // Checks
  assign res_read        = m_axis_tvalid_o && read_valid;
  assign res_drop        = m_axis_tvalid_o && (dropped != 2'd0);
  assign read_side_clear = (command == cet_pkg::CmdNone) && (dropped == 2'd0);

  `include "console_escape_translator_fifo_assert.svh"

  `CET_ASSERT_IMP(a_stall_has_head, clk_i, rst_ni, !s_axis_tready_o, q_stat.valid)
  `CET_ASSERT_IMP(a_read_no_side, clk_i, rst_ni, res_read, read_side_clear)
  `CET_ASSERT_IMP(a_drop_means_full, clk_i, rst_ni, res_drop, char_available)
  `CET_ASSERT_NXT(a_pop_gives_result, clk_i, rst_ni, pop, m_axis_tvalid_o)

endmodule
